// File: rtl/polytope_membership_test_top_macros.svh
// Assertion macros used by the checker file of the polytope membership test.
`ifndef POLYTOPE_MEMBERSHIP_TEST_TOP_MACROS_SVH
`define POLYTOPE_MEMBERSHIP_TEST_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pmt_pkg.sv
// Package with sizes, codes and shared types of the polytope membership test.
package pmt_pkg;

  localparam int MAX_INEQ = 16;
  localparam int MAX_DIM  = 8;

  localparam int VAL_W    = 32;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int ACC_W    = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int BND_SC_W = VAL_W + FRAC_W;

  localparam int ROW_W    = (MAX_INEQ > 1) ? $clog2(MAX_INEQ) : 1;
  localparam int COL_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int COEF_AW  = ROW_W + COL_W;

  localparam int MODE_W   = 2;
  localparam int ROWIN_W  = 4;
  localparam int COLIN_W  = 3;
  localparam int NINEQ_W  = 5;
  localparam int NDIM_W   = 4;
  localparam int CFG_W    = 5;
  localparam int CFGIDX_W = 1;

  localparam int DRAIN_CYC = 3;
  localparam int DRAIN_W   = $clog2(DRAIN_CYC);

  localparam logic [MODE_W-1:0] MODE_COEF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BOUND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POINT = 2'd2;

  localparam logic [CFGIDX_W-1:0] REG_NUM_INEQ = 1'd0;
  localparam logic [CFGIDX_W-1:0] REG_NUM_DIM  = 1'd1;

  localparam logic [NINEQ_W-1:0] NUM_INEQ_RST = 5'd2;
  localparam logic [NDIM_W-1:0]  NUM_DIM_RST  = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } pmt_state_t;

  typedef struct packed {
    logic             clear;
    logic             issue;
    logic             first;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pmt_cmd_t;

  typedef struct packed {
    logic             test_req;
    logic             fail;
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] last_col;
  } pmt_sts_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } pmt_tag_t;

endpackage

// File: rtl/pmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/pmt_ctrl.sv
// Controller state machine that sequences the row and column walk of a test.
module pmt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  pmt_pkg::pmt_sts_t sts,
  output pmt_pkg::pmt_cmd_t cmd,
  output logic              busy,
  output logic              done
);

  import pmt_pkg::*;

  pmt_state_t         state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [DRAIN_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.row   = row_r;
    cmd.col   = col_r;
    cmd.first = (col_r == '0);
    cmd.last  = (col_r == sts.last_col);
    busy      = 1'b1;
    done      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept && sts.test_req) begin
          cmd.clear = 1'b1;
          row_nxt   = '0;
          col_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (col_r == sts.last_col) begin
          col_nxt = '0;
          if (row_r == sts.last_row) begin
            cnt_nxt   = '0;
            state_nxt = ST_DRAIN;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DRAIN_W'(DRAIN_CYC - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pmt_dp.sv
// Datapath with the stores, the multiply-accumulate pipeline and the bound compare.
module pmt_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [pmt_pkg::MODE_W-1:0]           in_mode,
  input  logic [pmt_pkg::ROWIN_W-1:0]          in_row,
  input  logic [pmt_pkg::COLIN_W-1:0]          in_column,
  input  logic signed [pmt_pkg::VAL_W-1:0]     in_value,
  input  logic                                 in_last,
  input  logic                                 cfg_we,
  input  logic [pmt_pkg::CFGIDX_W-1:0]         cfg_index,
  input  logic [pmt_pkg::CFG_W-1:0]            cfg_wdata,
  input  pmt_pkg::pmt_cmd_t                    cmd,
  output pmt_pkg::pmt_sts_t                    sts
);

  import pmt_pkg::*;

  logic [NINEQ_W-1:0]         num_ineq_r;
  logic [NDIM_W-1:0]          num_dim_r;
  logic                       row_ok, col_ok;
  logic                       coef_we, bnd_we, pt_we;
  logic [VAL_W-1:0]           coef_rd, bnd_rd, pt_rd;
  pmt_tag_t                   t1_r, t2_r, t3_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [VAL_W-1:0]    bnd2_r, bnd3_r;
  logic signed [BND_SC_W-1:0] bnd_sc;
  logic                       below;
  logic                       fail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ineq_r <= NUM_INEQ_RST;
      num_dim_r  <= NUM_DIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_INEQ: num_ineq_r <= cfg_wdata[NINEQ_W-1:0];
        REG_NUM_DIM:  num_dim_r  <= cfg_wdata[NDIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.test_req = (in_mode == MODE_POINT) && in_last;
    sts.fail     = fail_r;
    if (num_ineq_r == '0) begin
      sts.last_row = '0;
    end else if (32'(num_ineq_r) > MAX_INEQ) begin
      sts.last_row = ROW_W'(MAX_INEQ - 1);
    end else begin
      sts.last_row = ROW_W'(num_ineq_r - 1'b1);
    end
    if (num_dim_r == '0) begin
      sts.last_col = '0;
    end else if (32'(num_dim_r) > MAX_DIM) begin
      sts.last_col = COL_W'(MAX_DIM - 1);
    end else begin
      sts.last_col = COL_W'(num_dim_r - 1'b1);
    end
  end

  assign row_ok  = 32'(in_row) < MAX_INEQ;
  assign col_ok  = 32'(in_column) < MAX_DIM;
  assign coef_we = accept && (in_mode == MODE_COEF) && row_ok && col_ok;
  assign bnd_we  = accept && (in_mode == MODE_BOUND) && row_ok;
  assign pt_we   = accept && (in_mode == MODE_POINT) && col_ok;

  pmt_ram #(.WIDTH(VAL_W), .DEPTH(MAX_INEQ * MAX_DIM)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr ({ROW_W'(in_row), COL_W'(in_column)}),
    .wdata (in_value),
    .raddr ({cmd.row, cmd.col}),
    .rdata (coef_rd)
  );

  pmt_ram #(.WIDTH(VAL_W), .DEPTH(MAX_INEQ)) u_bnd_ram (
    .clk   (clk),
    .we    (bnd_we),
    .waddr (ROW_W'(in_row)),
    .wdata (in_value),
    .raddr (cmd.row),
    .rdata (bnd_rd)
  );

  pmt_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (COL_W'(in_column)),
    .wdata (in_value),
    .raddr (cmd.col),
    .rdata (pt_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r   <= '0;
      t2_r   <= '0;
      t3_r   <= '0;
      fail_r <= 1'b0;
    end else begin
      t1_r   <= '{vld: cmd.issue, first: cmd.first, last: cmd.last};
      t2_r   <= t1_r;
      t3_r   <= t2_r;
      if (cmd.clear) begin
        fail_r <= 1'b0;
      end else if (t3_r.vld && t3_r.last && below) begin
        fail_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(coef_rd) * $signed(pt_rd);
    bnd2_r <= $signed(bnd_rd);
    bnd3_r <= bnd2_r;
    if (t2_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_nxt = t2_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
  assign bnd_sc  = $signed({bnd3_r, FRAC_W'(0)});
  assign below   = acc_r < ACC_W'(bnd_sc);

endmodule

// File: rtl/polytope_membership_test_top.sv
// Top level of the point in convex polytope membership test.
// Loads and coordinates not marked last are accepted back to back.
// A coordinate marked last starts a test: one multiply-accumulate per cycle over k rows
// and l columns, then a pipeline drain, after which out_strobe is raised; busy stays high
// up to and including the strobe, and the next item is accepted only once busy has fallen.
// Synchronous active-low reset sets num_ineq to 2 and num_dim to 1; the stores are not cleared.
module polytope_membership_test_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [pmt_pkg::MODE_W-1:0]       in_mode,
  input  logic [pmt_pkg::ROWIN_W-1:0]      in_row,
  input  logic [pmt_pkg::COLIN_W-1:0]      in_column,
  input  logic signed [pmt_pkg::VAL_W-1:0] in_value,
  input  logic                             in_last,
  output logic                             out_strobe,
  output logic                             out_inside_res,
  input  logic                             cfg_we,
  input  logic [pmt_pkg::CFGIDX_W-1:0]     cfg_index,
  input  logic [pmt_pkg::CFG_W-1:0]        cfg_wdata
);

  import pmt_pkg::*;

  logic     accept;
  logic     done;
  pmt_cmd_t cmd;
  pmt_sts_t sts;

  assign accept = start && !busy;

  pmt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  pmt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_mode   (in_mode),
    .in_row    (in_row),
    .in_column (in_column),
    .in_value  (in_value),
    .in_last   (in_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign out_strobe     = done;
  assign out_inside_res = !sts.fail;

endmodule

// File: rtl/pmt_checker.sv
// Port-level checker for the polytope membership test and its bind to the top level.
`include "polytope_membership_test_top_macros.svh"

module pmt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [pmt_pkg::MODE_W-1:0] in_mode,
  input logic                       in_last,
  input logic                       out_strobe
);

  import pmt_pkg::*;

  `PMT_ASSERT_NOW(a_strobe_busy, out_strobe, busy, "result strobe while not busy")
  `PMT_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe longer than one cycle")
  `PMT_ASSERT_NEXT(a_test_starts, start && !busy && (in_mode == MODE_POINT) && in_last, busy, "test item did not raise busy")
  `PMT_ASSERT_NEXT(a_load_quick, start && !busy && !((in_mode == MODE_POINT) && in_last), !busy && !out_strobe, "plain item made the block busy")
  `PMT_ASSERT_NOW(a_busy_ends, $fell(busy) && $past(rst_n), $past(out_strobe), "busy fell without a result")

endmodule

bind polytope_membership_test_top pmt_checker u_pmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_mode    (in_mode),
  .in_last    (in_last),
  .out_strobe (out_strobe)
);

// File: tb/polytope_membership_test_top_test.sv
// Self-checking testbench for the polytope membership test with random loads and point tests.
module polytope_membership_test_top_test;
  import pmt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TEST_CYCLES = MAX_INEQ * MAX_DIM + 8;
  localparam int LOAD_SETTLE = 8;
  localparam int ITEM_TARGET = 650;
  localparam int NUM_PHASES  = 12;
  localparam logic [CFG_W-1:0] ROW_SETS [9] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3,
                                                5'd2, 5'd8, 5'd1};
  localparam logic [CFG_W-1:0] DIM_SETS [9] = '{5'd1, 5'd8, 5'd0, 5'h1F, 5'd9, 5'd4,
                                                5'd8, 5'd2, 5'd8};

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [ROWIN_W-1:0]      row;
    logic [COLIN_W-1:0]      column;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    int                      gap;
  } pmt_op_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [MODE_W-1:0]       in_mode = '0;
  logic [ROWIN_W-1:0]      in_row = '0;
  logic [COLIN_W-1:0]      in_column = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    in_last = 1'b0;
  logic                    out_strobe;
  logic                    out_inside_res;
  logic                    cfg_we = 1'b0;
  logic [CFGIDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  pmt_op_t op_queue[$];
  logic    inside_expected[$];
  pmt_op_t cur_op;
  logic    want_inside;
  bit      took = 1'b0;
  int      gap_cnt = 0;
  int      err_cnt = 0;
  int      idle_cycles = 0;

  logic signed [VAL_W-1:0] coef_mat [MAX_INEQ][MAX_DIM];
  logic signed [VAL_W-1:0] bound_vec [MAX_INEQ];
  logic signed [VAL_W-1:0] point_vec [MAX_DIM];
  logic [NINEQ_W-1:0]      rows_reg = NUM_INEQ_RST;
  logic [NDIM_W-1:0]       dims_reg = NUM_DIM_RST;

  bit coef_set [MAX_INEQ][MAX_DIM];
  bit bound_set [MAX_INEQ];
  bit point_set [MAX_DIM];
  int gen_rows = 2;
  int gen_dims = 1;
  bit idle_on = 1'b0;
  int op_count = 0;

  polytope_membership_test_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_strobe     (out_strobe),
    .out_inside_res (out_inside_res),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic point_is_inside();
    int k;
    int l;
    logic signed [127:0]       acc;
    logic signed [127:0]       floor_val;
    logic signed [2*VAL_W-1:0] prod;
    k = clamp_count(int'(rows_reg), MAX_INEQ);
    l = clamp_count(int'(dims_reg), MAX_DIM);
    for (int r = 0; r < k; r++) begin
      acc = '0;
      for (int c = 0; c < l; c++) begin
        prod = coef_mat[r][c] * point_vec[c];
        acc = acc + prod;
      end
      floor_val = bound_vec[r];
      floor_val = floor_val <<< FRAC_W;
      if (acc < floor_val) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic apply_op(logic [MODE_W-1:0] mode, logic [ROWIN_W-1:0] row,
                          logic [COLIN_W-1:0] column, logic signed [VAL_W-1:0] value,
                          logic last);
    case (mode)
      MODE_COEF: coef_mat[row][column] = value;
      MODE_BOUND: bound_vec[row] = value;
      MODE_POINT: begin
        point_vec[column] = value;
        if (last) inside_expected.push_back(point_is_inside());
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    took = rst_n && start && !busy;
    if (!rst_n) begin
      rows_reg = NUM_INEQ_RST;
      dims_reg = NUM_DIM_RST;
    end else begin
      if (out_strobe) begin
        if (inside_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result inside_res=%0b", out_inside_res));
        end else begin
          want_inside = inside_expected.pop_front();
          if (out_inside_res !== want_inside)
            report_mismatch($sformatf("inside_res=%0b, expected %0b",
                                      out_inside_res, want_inside));
        end
      end
      if (took) apply_op(in_mode, in_row, in_column, in_value, in_last);
      if (cfg_we) begin
        if (cfg_index == REG_NUM_INEQ) rows_reg = cfg_wdata[NINEQ_W-1:0];
        else dims_reg = cfg_wdata[NDIM_W-1:0];
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_cnt > 0) begin
        start <= 1'b0;
        gap_cnt--;
      end else if (op_queue.size() != 0) begin
        cur_op = op_queue.pop_front();
        in_mode <= cur_op.mode;
        in_row <= cur_op.row;
        in_column <= cur_op.column;
        in_value <= cur_op.value;
        in_last <= cur_op.last;
        start <= 1'b1;
        gap_cnt = cur_op.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("polytope_membership_test_top_test: errors");
        $finish;
      end
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom();
      4: return '0;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_bound();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0030_0000;
    endcase
  endfunction

  task automatic push_op(logic [MODE_W-1:0] mode, int row, int column,
                         logic [VAL_W-1:0] value, logic last);
    pmt_op_t op;
    op.mode = mode;
    op.row = ROWIN_W'(row);
    op.column = COLIN_W'(column);
    op.value = value;
    op.last = last;
    op.gap = idle_on ? $urandom_range(0, 14) : 0;
    op_queue.push_back(op);
    case (mode)
      MODE_COEF: coef_set[row][column] = 1'b1;
      MODE_BOUND: bound_set[row] = 1'b1;
      MODE_POINT: point_set[column] = 1'b1;
      default: ;
    endcase
    if (mode != MODE_UNUSED) op_count++;
  endtask

  task automatic fill_missing();
    for (int r = 0; r < gen_rows; r++)
      for (int c = 0; c < gen_dims; c++)
        if (!coef_set[r][c])
          push_op(MODE_COEF, r, c, rand_value(), 1'($urandom_range(0, 1)));
    for (int r = 0; r < gen_rows; r++)
      if (!bound_set[r])
        push_op(MODE_BOUND, r, $urandom_range(0, 7), rand_bound(), 1'($urandom_range(0, 1)));
    for (int c = 0; c < gen_dims; c++)
      if (!point_set[c]) push_op(MODE_POINT, $urandom_range(0, 15), c, rand_value(), 1'b0);
  endtask

  task automatic point_test();
    int n_upd;
    int last_col;
    fill_missing();
    n_upd = $urandom_range(0, 3);
    repeat (n_upd) begin
      if ($urandom_range(0, 1))
        push_op(MODE_COEF, $urandom_range(0, gen_rows - 1), $urandom_range(0, gen_dims - 1),
                rand_value(), 1'($urandom_range(0, 1)));
      else
        push_op(MODE_BOUND, $urandom_range(0, gen_rows - 1), $urandom_range(0, 7),
                rand_bound(), 1'($urandom_range(0, 1)));
    end
    last_col = $urandom_range(0, gen_dims - 1);
    for (int c = 0; c < gen_dims; c++)
      if (c != last_col && $urandom_range(0, 5) != 0)
        push_op(MODE_POINT, $urandom_range(0, 15), c, rand_value(), 1'b0);
    push_op(MODE_POINT, $urandom_range(0, 15), last_col, rand_value(), 1'b1);
  endtask

  task automatic noise_op();
    case ($urandom_range(0, 4))
      0: push_op(MODE_UNUSED, $urandom_range(0, 15), $urandom_range(0, 7), $urandom(),
                 1'($urandom_range(0, 1)));
      1: push_op(MODE_COEF, $urandom_range(0, 15), $urandom_range(0, 7), rand_value(), 1'b1);
      2: push_op(MODE_BOUND, $urandom_range(0, 15), $urandom_range(0, 7), rand_bound(), 1'b1);
      3: push_op(MODE_POINT, $urandom_range(0, 15), $urandom_range(0, 7), rand_value(), 1'b0);
      default: begin
        fill_missing();
        push_op(MODE_POINT, $urandom_range(0, 15), $urandom_range(0, 7), rand_value(), 1'b1);
      end
    endcase
  endtask

  task automatic write_reg(logic [CFGIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_INEQ) gen_rows = clamp_count(int'(data[NINEQ_W-1:0]), MAX_INEQ);
    else gen_dims = clamp_count(int'(data[NDIM_W-1:0]), MAX_DIM);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (op_queue.size() != 0 || start || busy || inside_expected.size() != 0);
    repeat (LOAD_SETTLE) @(negedge clk);
  endtask

  initial begin
    int goal;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: two rows, one dimension.
    push_op(MODE_COEF, 0, 0, 32'h0001_0000, 1'b0);
    push_op(MODE_COEF, 1, 0, 32'hFFFF_0000, 1'b1);
    push_op(MODE_BOUND, 0, 0, 32'h0000_0000, 1'b0);
    push_op(MODE_BOUND, 1, 0, 32'hFFFE_0000, 1'b1);
    push_op(MODE_POINT, 0, 0, 32'h0001_0000, 1'b1);
    push_op(MODE_POINT, 0, 0, 32'h0003_0000, 1'b1);
    push_op(MODE_POINT, 0, 0, 32'hFFFF_8000, 1'b1);
    push_op(MODE_UNUSED, 15, 7, 32'hFFFF_FFFF, 1'b1);
    push_op(MODE_POINT, 15, 7, 32'h1234_5678, 1'b1);
    push_op(MODE_POINT, 0, 0, 32'h0000_0000, 1'b1);
    push_op(MODE_COEF, 0, 0, 32'h8000_0000, 1'b0);
    push_op(MODE_COEF, 1, 0, 32'h7FFF_FFFF, 1'b0);
    push_op(MODE_BOUND, 0, 0, 32'h7FFF_FFFF, 1'b0);
    push_op(MODE_BOUND, 1, 0, 32'h8000_0000, 1'b0);
    push_op(MODE_POINT, 0, 0, 32'h8000_0000, 1'b1);
    push_op(MODE_POINT, 0, 0, 32'h7FFF_FFFF, 1'b1);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 9) begin
        write_reg(REG_NUM_INEQ, ROW_SETS[p]);
        write_reg(REG_NUM_DIM, DIM_SETS[p]);
      end else begin
        write_reg(REG_NUM_DIM, CFG_W'($urandom_range(0, 31)));
        write_reg(REG_NUM_INEQ, CFG_W'($urandom_range(0, 31)));
      end
      goal = 16 + (ITEM_TARGET * (p + 1)) / NUM_PHASES;
      while (op_count < goal) begin
        idle_on = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 9) < 7) point_test();
        else noise_op();
      end
      wait_idle();
    end

    repeat (TEST_CYCLES) @(posedge clk);
    if (inside_expected.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", inside_expected.size()));
    if (err_cnt == 0) begin
      $display("polytope_membership_test_top_test: clean");
    end else begin
      $display("polytope_membership_test_top_test: errors");
    end
    $finish;
  end

endmodule
